### hdl/nfm_pkg.sv
// Package for the node field magnitude block: widths, constants and types.
// No dependencies.
`default_nettype none
package nfm_pkg;

    localparam int unsigned PosW  = 32;
    localparam int unsigned SumW  = 48;
    localparam int unsigned OutW  = 40;
    localparam int unsigned DiffW = 33;
    localparam int unsigned D2W   = 68;
    localparam int unsigned NumW  = 90;
    localparam int unsigned SqW   = 97;
    localparam int unsigned RootW = 49;

    localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
    localparam logic [SumW:0]   TermCap = {1'b1, {SumW{1'b0}}};

    localparam logic OpCentre    = 1'b0;
    localparam logic OpNeighbour = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_D2,
        ST_NUM,
        ST_DIV,
        ST_ACC,
        ST_SSQ,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_centre;
        logic diff;
        logic sq_step;
        logic d2_sum;
        logic num;
        logic div_start;
        logic acc;
        logic ssq_step;
        logic sqrt_start;
        logic out_load;
        logic out_zero;
        logic [1:0] axis;
        logic [1:0] part;
    } t_cmd;

    typedef struct packed {
        logic zero_dist;
        logic div_busy;
        logic sqrt_busy;
    } t_status;

endpackage
`default_nettype wire

### hdl/nfm_if.sv
// Valid/ready channel interfaces for the node field magnitude block.
// Depends on nfm_pkg.
`default_nettype none
interface nfm_in_if import nfm_pkg::*; ();
    logic valid;
    logic ready;
    logic opcode;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [PosW-1:0] potential;
    logic is_last;
    modport source (output valid, opcode, pos_x, pos_y, pos_z, potential, is_last,
                    input ready);
    modport sink (input valid, opcode, pos_x, pos_y, pos_z, potential, is_last,
                  output ready);
endinterface

interface nfm_out_if import nfm_pkg::*; ();
    logic valid;
    logic ready;
    logic [OutW-1:0] field_magnitude;
    logic zero_distance_seen;
    logic overflow;
    modport source (output valid, field_magnitude, zero_distance_seen, overflow,
                    input ready);
    modport sink (input valid, field_magnitude, zero_distance_seen, overflow,
                  output ready);
endinterface
`default_nettype wire

### hdl/nfm_ctrl.sv
// Controller state machine that sequences the datapath for one item.
// Depends on nfm_pkg.
`default_nettype none
module nfm_ctrl import nfm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_opcode,
    input  wire logic    i_is_last,
    input  wire logic    i_out_free,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_part, n_part;
    logic       r_last, n_last;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
            r_part  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_part  <= n_part;
            r_last  <= n_last;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_part     = r_part;
        n_last     = r_last;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_cmd.part = r_part;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_out_free;
                if (i_in_valid && i_out_free) begin
                    n_last = i_is_last;
                    n_axis = '0;
                    if (i_opcode == OpCentre) begin
                        o_cmd.load_centre = 1'b1;
                        o_cmd.out_zero    = i_is_last;
                    end else begin
                        o_cmd.diff = 1'b1;
                        n_state    = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                o_cmd.sq_step = 1'b1;
                if (r_axis == 2'd2) begin
                    n_axis  = '0;
                    n_state = ST_D2;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            ST_D2: begin
                o_cmd.d2_sum = 1'b1;
                n_state      = ST_SQ;
            end
            ST_SQ: begin
                if (i_status.zero_dist) begin
                    n_state = r_last ? ST_SSQ : ST_IDLE;
                end else begin
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_ACC;
            end
            ST_ACC: begin
                if (!i_status.div_busy) begin
                    o_cmd.acc = 1'b1;
                    if (r_axis == 2'd2) begin
                        n_axis  = '0;
                        n_state = r_last ? ST_SSQ : ST_IDLE;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = ST_NUM;
                    end
                end
            end
            // Three partial products per axis for the sum of squares.
            ST_SSQ: begin
                o_cmd.ssq_step = 1'b1;
                if (r_part == 2'd2) begin
                    n_part = '0;
                    if (r_axis == 2'd2) begin
                        n_axis  = '0;
                        n_state = ST_SQRT;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_part = r_part + 2'd1;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_OUT;
            end
            ST_OUT: begin
                if (!i_status.sqrt_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### hdl/nfm_dp.sv
// Datapath: centre store, sums, squarer, serial divider and serial root.
// Depends on nfm_pkg.
`default_nettype none
module nfm_dp import nfm_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic signed [PosW-1:0] i_pos_x,
    input  wire logic signed [PosW-1:0] i_pos_y,
    input  wire logic signed [PosW-1:0] i_pos_z,
    input  wire logic signed [PosW-1:0] i_potential,
    input  wire logic                   i_out_ready,
    output t_status                     o_status,
    output logic                        o_out_valid,
    output logic [OutW-1:0]             o_field_magnitude,
    output logic                        o_zero_distance_seen,
    output logic                        o_overflow
);

    localparam int unsigned DivCntW = $clog2(NumW + 1);
    localparam int unsigned SqCntW  = $clog2(RootW + 1);
    localparam int unsigned HalfW   = SumW / 2;
    localparam int unsigned SqInW   = 2 * RootW;
    localparam int unsigned SqRemW  = RootW + 3;

    logic signed [PosW-1:0] r_cx, r_cy, r_cz, r_cv;
    logic signed [SumW-1:0] r_sum [3];
    logic [1:0]             r_flags;
    logic [DiffW-1:0]       r_dmag [3];
    logic                   r_dneg [3];
    logic [DiffW-1:0]       r_vmag;
    logic                   r_vneg;
    logic [D2W-1:0]         r_sq [3];
    logic [D2W-1:0]         r_d2;
    logic [SqW-1:0]         r_ssq;
    logic                   r_zchk;

    // Divider registers: restoring, one quotient bit per cycle.
    logic [NumW-1:0]    r_num;
    logic [D2W:0]       r_rem;
    logic [DivCntW-1:0] r_dcnt;
    logic               r_dbusy;
    logic               r_tneg;

    // Root registers: one result bit per cycle.
    logic [RootW-1:0]  r_root;
    logic [SqInW-1:0]  r_sqin;
    logic [SqRemW-1:0] r_srem;
    logic [SqCntW-1:0] r_scnt;
    logic              r_sbusy;
    logic [SqRemW-1:0] w_srem_sh;
    logic [SqRemW-1:0] w_strial;
    logic [SqRemW-1:0] w_srem_sub;

    logic                   r_ovalid;
    logic [OutW-1:0]        r_omag;
    logic                   r_ozero, r_oovf;

    logic signed [DiffW-1:0] w_dx, w_dy, w_dz, w_dv;
    logic [DiffW-1:0]        w_sel_mag;
    logic [2*DiffW-1:0]      w_sq;
    logic [SumW-1:0]         w_sum_mag;
    logic [HalfW-1:0]        w_ssq_a, w_ssq_b;
    logic [2*HalfW-1:0]      w_ssq_prod;
    logic [SqW-1:0]          w_ssq_term;
    logic [D2W:0]            w_rem_sh;
    logic [D2W:0]            w_rem_sub;
    logic [2*DiffW-1:0]      w_num_prod;
    logic [SumW:0]           w_q;
    logic signed [SumW+1:0]  w_term, w_tot;
    logic [RootW-5:0]        w_root_sh;

    assign w_dx = DiffW'(r_cx) - DiffW'(i_pos_x);
    assign w_dy = DiffW'(r_cy) - DiffW'(i_pos_y);
    assign w_dz = DiffW'(r_cz) - DiffW'(i_pos_z);
    assign w_dv = DiffW'(r_cv) - DiffW'(i_potential);

    // One multiplier, shared by the distance squares and the numerators.
    assign w_sel_mag = r_dmag[i_cmd.axis];
    assign w_sq      = w_sel_mag * (i_cmd.num ? r_vmag : w_sel_mag);
    assign w_num_prod = w_sq;

    // Sum squares from 24-bit halves: low*low, then 2*high*low, then high*high,
    // one partial product per cycle.
    assign w_sum_mag = r_sum[i_cmd.axis][SumW-1] ? SumW'(-r_sum[i_cmd.axis])
                                                 : SumW'(r_sum[i_cmd.axis]);
    assign w_ssq_a    = (i_cmd.part == 2'd2) ? w_sum_mag[SumW-1:HalfW] : w_sum_mag[HalfW-1:0];
    assign w_ssq_b    = (i_cmd.part == 2'd0) ? w_sum_mag[HalfW-1:0] : w_sum_mag[SumW-1:HalfW];
    assign w_ssq_prod = w_ssq_a * w_ssq_b;

    always_comb begin
        case (i_cmd.part)
            2'd0:    w_ssq_term = SqW'(w_ssq_prod);
            2'd1:    w_ssq_term = SqW'(w_ssq_prod) << (HalfW + 1);
            default: w_ssq_term = SqW'(w_ssq_prod) << SumW;
        endcase
    end

    assign w_rem_sh  = {r_rem[D2W-1:0], r_num[NumW-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_d2};

    // Quotient is the low numerator bits after the shift-out; clamp at the cap.
    assign w_q    = (r_num > NumW'(TermCap)) ? TermCap : (SumW+1)'(r_num);
    assign w_term = r_tneg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_tot  = w_term + (SumW+2)'(r_sum[i_cmd.axis]);

    // Root step: bring down two radicand bits and try 4*root + 1.
    assign w_srem_sh  = {r_srem[SqRemW-3:0], r_sqin[SqInW-1:SqInW-2]};
    assign w_strial   = {1'b0, r_root, 2'b01};
    assign w_srem_sub = w_srem_sh - w_strial;
    assign w_root_sh  = r_root[RootW-1:4];

    // Centre, sums and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_cv    <= '0;
            r_sum   <= '{default: '0};
            r_flags <= '0;
        end else begin
            if (i_cmd.load_centre) begin
                r_cx    <= i_pos_x;
                r_cy    <= i_pos_y;
                r_cz    <= i_pos_z;
                r_cv    <= i_potential;
                r_sum   <= '{default: '0};
                r_flags <= '0;
            end
            if (r_zchk && o_status.zero_dist) begin
                r_flags[0] <= 1'b1;
            end
            if (i_cmd.acc) begin
                if (w_tot > $signed({2'b00, SumMax})) begin
                    r_sum[i_cmd.axis] <= SumMax;
                    r_flags[1]        <= 1'b1;
                end else if (w_tot < $signed({2'b11, SumMin})) begin
                    r_sum[i_cmd.axis] <= SumMin;
                    r_flags[1]        <= 1'b1;
                end else begin
                    r_sum[i_cmd.axis] <= SumW'(w_tot);
                end
            end
            if (i_cmd.out_load && r_root[RootW-1:4+OutW] != '0) begin
                r_flags[1] <= 1'b1;
            end
        end
    end

    // Zero-distance check pulse, in the cycle after the distance sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zchk <= 1'b0;
        end else begin
            r_zchk <= i_cmd.d2_sum;
        end
    end
    assign o_status.zero_dist = (r_d2 == '0);
    assign o_status.div_busy  = r_dbusy;
    assign o_status.sqrt_busy = r_sbusy;

    // Operand capture and products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_dneg[0] <= w_dx[DiffW-1];
            r_dneg[1] <= w_dy[DiffW-1];
            r_dneg[2] <= w_dz[DiffW-1];
            r_dmag[0] <= w_dx[DiffW-1] ? -w_dx : w_dx;
            r_dmag[1] <= w_dy[DiffW-1] ? -w_dy : w_dy;
            r_dmag[2] <= w_dz[DiffW-1] ? -w_dz : w_dz;
            r_vneg    <= w_dv[DiffW-1];
            r_vmag    <= w_dv[DiffW-1] ? -w_dv : w_dv;
        end
        if (i_cmd.sq_step) begin
            r_sq[i_cmd.axis] <= D2W'(w_sq);
        end
        if (i_cmd.d2_sum) begin
            r_d2 <= r_sq[0] + r_sq[1] + r_sq[2];
        end
        if (i_cmd.ssq_step) begin
            r_ssq <= (i_cmd.axis == 2'd0 && i_cmd.part == 2'd0) ? w_ssq_term
                                                                : r_ssq + w_ssq_term;
        end
    end

    // Serial divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.num) begin
            r_num  <= {w_num_prod, 24'd0};
            r_tneg <= r_vneg ^ r_dneg[i_cmd.axis];
            r_rem  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= DivCntW'(NumW);
        end else if (r_dbusy) begin
            if (!w_rem_sub[D2W]) begin
                r_rem <= w_rem_sub;
                r_num <= {r_num[NumW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_num <= {r_num[NumW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - DivCntW'(1);
            if (r_dcnt == DivCntW'(1)) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    // Serial integer square root, two radicand bits per step from the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_scnt  <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sbusy <= 1'b1;
            r_root  <= '0;
            r_srem  <= '0;
            r_sqin  <= SqInW'(r_ssq);
            r_scnt  <= SqCntW'(RootW - 1);
        end else if (r_sbusy) begin
            r_sqin <= {r_sqin[SqInW-3:0], 2'b00};
            if (w_srem_sh >= w_strial) begin
                r_srem <= w_srem_sub;
                r_root <= {r_root[RootW-2:0], 1'b1};
            end else begin
                r_srem <= w_srem_sh;
                r_root <= {r_root[RootW-2:0], 1'b0};
            end
            if (r_scnt == '0) begin
                r_sbusy <= 1'b0;
            end else begin
                r_scnt <= r_scnt - SqCntW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.out_zero) begin
                r_ovalid <= 1'b1;
                r_omag   <= '0;
                r_ozero  <= 1'b0;
                r_oovf   <= 1'b0;
            end else if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_ozero  <= r_flags[0];
                if (r_root[RootW-1:4+OutW] != '0) begin
                    r_omag <= {OutW{1'b1}};
                    r_oovf <= 1'b1;
                end else begin
                    r_omag <= OutW'(w_root_sh);
                    r_oovf <= r_flags[1];
                end
            end
        end
    end

    assign o_out_valid          = r_ovalid;
    assign o_field_magnitude    = r_omag;
    assign o_zero_distance_seen = r_ozero;
    assign o_overflow           = r_oovf;

endmodule
`default_nettype wire

### hdl/node_field_magnitude_top.sv
// Node field magnitude top level. A centre item is stored on accept; a centre flagged last
// has its zero result valid the next cycle. A neighbour goes through accept, three
// squares, distance sum, check, then per axis setup, serial divide and accumulate.
// A zero-distance neighbour ends after the check. A last item adds the sum-of-squares
// steps, root start, serial root and output load; input waits while a result is untaken.
// Synchronous active-low reset clears the centre, the sums, flags and control.
`default_nettype none
module node_field_magnitude_top import nfm_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    nfm_in_if.sink   in_ch,
    nfm_out_if.source out_ch
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_out_free;

    assign w_out_free = !out_ch.valid || out_ch.ready;

    // Controller.
    nfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_opcode   (in_ch.opcode),
        .i_is_last  (in_ch.is_last),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_in_ready (in_ch.ready),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    nfm_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_pos_x              (in_ch.pos_x),
        .i_pos_y              (in_ch.pos_y),
        .i_pos_z              (in_ch.pos_z),
        .i_potential          (in_ch.potential),
        .i_out_ready          (out_ch.ready),
        .o_status             (w_status),
        .o_out_valid          (out_ch.valid),
        .o_field_magnitude    (out_ch.field_magnitude),
        .o_zero_distance_seen (out_ch.zero_distance_seen),
        .o_overflow           (out_ch.overflow)
    );

endmodule
`default_nettype wire

### hdl/nfm_checker.sv
// Port-level checker for the node field magnitude top level, with its bind.
// Depends on nfm_pkg and the channel interfaces.
`default_nettype none
module nfm_checker import nfm_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_opcode,
    input wire logic i_is_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [OutW-1:0] i_mag,
    input wire logic i_zero
);

    // A result stays put until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mag))
        else $error("result dropped or changed while stalled");

    // A last centre yields a zero result next cycle.
    a_centre_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_opcode == OpCentre && i_is_last
        |=> i_out_valid && i_mag == '0 && !i_zero)
        else $error("centre flagged last gave no zero result");

    // A neighbour keeps the input side busy the next cycle.
    a_nb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_opcode == OpNeighbour |=> !i_in_ready)
        else $error("input taken while a neighbour is in work");

    // Items that produce nothing never raise valid.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !(i_in_valid && i_in_ready && i_opcode == OpCentre && i_is_last)
        && i_in_ready |=> !i_out_valid)
        else $error("result appeared from nothing");

endmodule

bind node_field_magnitude_top nfm_checker u_nfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_opcode    (in_ch.opcode),
    .i_is_last   (in_ch.is_last),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_mag       (out_ch.field_magnitude),
    .i_zero      (out_ch.zero_distance_seen)
);
`default_nettype wire

### tb/nfm_field_checker.sv
// Checker for the node field magnitude block: watches both channels, predicts
// each field magnitude result and compares it. Depends on nfm_pkg and nfm_if.sv.
`timescale 1ns / 1ps
`default_nettype none
module nfm_field_checker import nfm_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    nfm_in_if        in_ch,
    nfm_out_if       out_ch,
    output int       o_fail_count,
    output int       o_pending
);

    localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint AccMin = -64'sh0000_8000_0000_0000;
    localparam logic [127:0] TermLimit = 128'h1 << 48;
    localparam logic [63:0] MagLimit = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [OutW-1:0] magnitude;
        logic            zero_dist;
        logic            ovf;
    } t_field_result;

    // Predicted node state.
    longint centre_x, centre_y, centre_z, centre_v;
    longint axis_sum [3];
    logic   zero_seen, ovf_seen;

    t_field_result expected_fields [$];
    int fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_fields.size();

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Adds dV*d_axis/|d|^2 in Q24.24 to one axis sum, with clamp and saturation.
    function automatic void add_axis_term(int idx, longint dv, longint da,
                                          logic [127:0] d2);
        logic [127:0] num;
        logic [127:0] quo;
        longint t;
        num = ({64'b0, abs64(dv)} * {64'b0, abs64(da)}) << 24;
        quo = num / d2;
        if (quo > TermLimit) begin
            quo = TermLimit;
        end
        t = ((dv < 0) != (da < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        t = t + axis_sum[idx];
        if (t > AccMax) begin
            t = AccMax;
            ovf_seen = 1'b1;
        end
        if (t < AccMin) begin
            t = AccMin;
            ovf_seen = 1'b1;
        end
        axis_sum[idx] = t;
    endfunction

    // Floor square root of the sum of squares, scaled to Q20.20 and saturated.
    function automatic logic [OutW-1:0] field_root();
        logic [127:0] s;
        logic [63:0] r;
        logic [63:0] c;
        s = 128'b0;
        for (int i = 0; i < 3; i++) begin
            s = s + {64'b0, abs64(axis_sum[i])} * {64'b0, abs64(axis_sum[i])};
        end
        r = 64'b0;
        for (int b = 48; b >= 0; b--) begin
            c = r | (64'h1 << b);
            if (({64'b0, c} * {64'b0, c}) <= s) begin
                r = c;
            end
        end
        r = r >> 4;
        if (r > MagLimit) begin
            r = MagLimit;
            ovf_seen = 1'b1;
        end
        return r[OutW-1:0];
    endfunction

    function automatic void predict_item(logic op, longint px, longint py, longint pz,
                                         longint pv, logic last);
        longint dx, dy, dz, dv;
        logic [127:0] d2;
        t_field_result res;
        if (op == OpCentre) begin
            centre_x = px;
            centre_y = py;
            centre_z = pz;
            centre_v = pv;
            axis_sum = '{0, 0, 0};
            zero_seen = 1'b0;
            ovf_seen = 1'b0;
            if (last) begin
                res = '0;
                expected_fields.push_back(res);
            end
            return;
        end
        dx = centre_x - px;
        dy = centre_y - py;
        dz = centre_z - pz;
        dv = centre_v - pv;
        d2 = {64'b0, abs64(dx)} * {64'b0, abs64(dx)}
           + {64'b0, abs64(dy)} * {64'b0, abs64(dy)}
           + {64'b0, abs64(dz)} * {64'b0, abs64(dz)};
        if (d2 == 128'b0) begin
            zero_seen = 1'b1;
        end else begin
            add_axis_term(0, dv, dx, d2);
            add_axis_term(1, dv, dy, d2);
            add_axis_term(2, dv, dz, d2);
        end
        if (last) begin
            res.magnitude = field_root();
            res.zero_dist = zero_seen;
            res.ovf = ovf_seen;
            expected_fields.push_back(res);
        end
    endfunction

    // Predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        t_field_result exp_res;
        if (!i_rst_n) begin
            centre_x = 0;
            centre_y = 0;
            centre_z = 0;
            centre_v = 0;
            axis_sum = '{0, 0, 0};
            zero_seen = 1'b0;
            ovf_seen = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(in_ch.opcode, longint'(in_ch.pos_x), longint'(in_ch.pos_y),
                             longint'(in_ch.pos_z), longint'(in_ch.potential),
                             in_ch.is_last);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_fields.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: mag=%h zd=%b ovf=%b",
                                 out_ch.field_magnitude, out_ch.zero_distance_seen,
                                 out_ch.overflow);
                    end
                end else begin
                    exp_res = expected_fields.pop_front();
                    if (out_ch.field_magnitude !== exp_res.magnitude
                        || out_ch.zero_distance_seen !== exp_res.zero_dist
                        || out_ch.overflow !== exp_res.ovf) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"mismatch: mag exp %h got %h, zd exp %b got %b, ",
                                      "ovf exp %b got %b"},
                                     exp_res.magnitude, out_ch.field_magnitude,
                                     exp_res.zero_dist, out_ch.zero_distance_seen,
                                     exp_res.ovf, out_ch.overflow);
                        end
                    end
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        centre_x = 0;
        centre_y = 0;
        centre_z = 0;
        centre_v = 0;
        axis_sum = '{0, 0, 0};
        zero_seen = 1'b0;
        ovf_seen = 1'b0;
    end

endmodule
`default_nettype wire

### tb/tb_node_field_magnitude_top.sv
// Testbench top for the node field magnitude block: drives centre and neighbour
// items, stalls the result side, and gives the verdict. Depends on nfm_pkg,
// nfm_if.sv, nfm_field_checker and node_field_magnitude_top.
`timescale 1ns / 1ps
`default_nettype none
module tb_node_field_magnitude_top;
    import nfm_pkg::*;

    localparam int CycleLimit = 4000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    logic signed [PosW-1:0] node_x, node_y, node_z, node_v;

    nfm_in_if  in_ch ();
    nfm_out_if out_ch ();

    node_field_magnitude_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    nfm_field_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #4 i_clk = ~i_clk;

    // Result side: random stalls by phase.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb_node_field_magnitude_top failed");
            $finish;
        end
    end

    // One transfer on the input channel, with an optional gap before it.
    task automatic send_item(logic op, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [31:0] pv, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.pos_x     <= px;
        in_ch.pos_y     <= py;
        in_ch.pos_z     <= pz;
        in_ch.potential <= pv;
        in_ch.is_last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == OpCentre) begin
            node_x = px;
            node_y = py;
            node_z = pz;
            node_v = pv;
        end
    endtask

    // A value of mixed scale: full range, small, medium, or an extreme.
    function automatic logic [31:0] any_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(8388608)) - 4194304);
        endcase
    endfunction

    // A neighbour offset from the centre, sometimes tiny or zero, sometimes fully random.
    function automatic logic [31:0] near(logic [31:0] c);
        case ($urandom_range(4))
            0: return c;
            1: return c + 32'($signed($urandom_range(8)) - 4);
            2: return $urandom;
            default: return c + 32'($signed($urandom_range(1048576)) - 524288);
        endcase
    endfunction

    // A centre and its neighbours; the last item carries is_last.
    task automatic send_node(output int count);
        int n;
        n = $urandom_range(5);
        count = n + 1;
        send_item(OpCentre, any_value(), any_value(), any_value(), any_value(), n == 0);
        for (int k = 1; k <= n; k++) begin
            if ($urandom_range(19) == 0) begin
                send_item(OpNeighbour, node_x, node_y, node_z, any_value(), k == n);
            end else begin
                send_item(OpNeighbour, near(node_x), near(node_y), near(node_z),
                          near(node_v), k == n);
            end
        end
    endtask

    initial begin
        int sent;
        int cnt;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OpCentre;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.potential = '0;
        in_ch.is_last = 1'b0;
        out_ch.ready = 1'b0;
        node_x = '0;
        node_y = '0;
        node_z = '0;
        node_v = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a neighbour against the reset centre, then the extremes.
        send_item(OpNeighbour, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b1);
        send_item(OpCentre, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1);
        send_item(OpCentre, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 1'b0);
        send_item(OpNeighbour, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1'b1);
        // Zero distance, then a neighbour one LSB away with a huge potential step.
        send_item(OpCentre, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_item(OpNeighbour, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 1'b0);
        send_item(OpNeighbour, 32'h1, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
        send_item(OpNeighbour, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 1'b1);
        // Sums persist after a result: more neighbours without a fresh centre.
        send_item(OpNeighbour, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_item(OpNeighbour, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000,
                  32'h0, 1'b1);
        // Unit geometry with ordinary values, all signs.
        send_item(OpCentre, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0003_0000, 1'b0);
        send_item(OpNeighbour, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(OpNeighbour, 32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000,
                  32'h0005_0000, 1'b1);
        send_item(OpCentre, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 29 : 0;
            recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 29 : 0;
            sent = 0;
            while (sent < 470) begin
                if ($urandom_range(9) == 0) begin
                    // Loose item: any opcode, any flag.
                    send_item(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                              $urandom, 1'($urandom_range(1)));
                    sent++;
                end else begin
                    send_node(cnt);
                    sent += cnt;
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_node_field_magnitude_top passed");
        end else begin
            $display("tb_node_field_magnitude_top failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
